@@ sv/epl_pkg.sv @@
// Shared constants and types for the entry pool with lifetime.
`default_nettype none
package epl_pkg;
  localparam int POOL_SIZE = 1024;
  localparam int IDX_W     = $clog2(POOL_SIZE);
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);
  localparam int LIFE_W    = 16;

  localparam logic [1:0] CMD_SPAWN   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
  localparam logic [1:0] ST_NOT_ACTIVE = 2'd2;
endpackage
`default_nettype wire

@@ sv/epl_ram.sv @@
// Generic single write port RAM with registered read.
`default_nettype none
module epl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/entry_pool_with_lifetime.sv @@
// Entry pool with free stack, active list and per-entry lifetime counters.
// Spawn: SP_RD, SP_WR. Exhausted spawn or unused command: straight to FIN.
// Release: RL_RD, RL_CMP per slot scanned, then DR_RD, DR_WR when found.
// Tick: TK_NEXT, TK_RD, TK_RF per active entry, plus DR_RD, DR_WR per expired entry.
// One item at a time; the sequencer and its single decrement unit set the rate.
// Synchronous reset starts a clearing pass over all 1024 entries; s_tready stays low meanwhile.
`default_nettype none
module entry_pool_with_lifetime
  import epl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // lifetime[15:0], entry[25:16], zero
  input  wire logic [1:0]  s_tuser,   // command[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,   // granted_entry, expired_count, active_count, free_count
  output logic      [1:0]  m_tuser    // status[1:0]
);
  typedef enum logic [11:0] {
    S_CLR     = 12'b000000000001,
    S_IDLE    = 12'b000000000010,
    S_SP_RD   = 12'b000000000100,
    S_SP_WR   = 12'b000000001000,
    S_RL_RD   = 12'b000000010000,
    S_RL_CMP  = 12'b000000100000,
    S_TK_NEXT = 12'b000001000000,
    S_TK_RD   = 12'b000010000000,
    S_TK_RF   = 12'b000100000000,
    S_DR_RD   = 12'b001000000000,
    S_DR_WR   = 12'b010000000000,
    S_FIN     = 12'b100000000000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   clr_idx;
  logic [CNT_W-1:0]   free_depth;
  logic [CNT_W-1:0]   active_depth;
  logic [CNT_W-1:0]   walk;
  logic [CNT_W-1:0]   expired;
  logic [IDX_W-1:0]   drop_pos;
  logic [IDX_W-1:0]   drop_e;
  logic [IDX_W-1:0]   cur_e;
  logic               drop_tick;
  logic [LIFE_W-1:0]  life;
  logic [IDX_W-1:0]   ent;
  logic [1:0]         res_status;
  logic [IDX_W-1:0]   res_granted;

  logic               rf_we, fs_we, al_we;
  logic [IDX_W-1:0]   rf_waddr, fs_waddr, al_waddr;
  logic [LIFE_W-1:0]  rf_wdata;
  logic [IDX_W-1:0]   fs_wdata, al_wdata;
  logic [IDX_W-1:0]   rf_raddr, fs_raddr, al_raddr;
  logic [LIFE_W-1:0]  rf_rdata;
  logic [IDX_W-1:0]   fs_rdata, al_rdata;
  logic [LIFE_W-1:0]  dec;
  logic [CNT_W-1:0]   walk_m1;
  logic [CNT_W-1:0]   last;
  logic [CNT_W-1:0]   fd_m1;

  assign s_tready = (state == S_IDLE);
  assign dec      = rf_rdata - LIFE_W'(1);
  assign walk_m1  = walk - CNT_W'(1);
  assign last     = active_depth - CNT_W'(1);
  assign fd_m1    = free_depth - CNT_W'(1);

  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = cur_e;
    rf_wdata = '0;
    fs_we    = 1'b0;
    fs_waddr = free_depth[IDX_W-1:0];
    fs_wdata = drop_e;
    al_we    = 1'b0;
    al_waddr = drop_pos;
    al_wdata = al_rdata;
    rf_raddr = al_rdata;
    fs_raddr = fd_m1[IDX_W-1:0];
    al_raddr = walk_m1[IDX_W-1:0];
    unique case (state)
      S_CLR: begin
        rf_we    = 1'b1;
        rf_waddr = clr_idx[IDX_W-1:0];
        fs_we    = 1'b1;
        fs_waddr = clr_idx[IDX_W-1:0];
        fs_wdata = clr_idx[IDX_W-1:0];
      end
      S_SP_WR: begin
        rf_we    = 1'b1;
        rf_waddr = fs_rdata;
        rf_wdata = (life == '0) ? LIFE_W'(1) : life;
        al_we    = 1'b1;
        al_waddr = active_depth[IDX_W-1:0];
        al_wdata = fs_rdata;
      end
      S_RL_RD:  al_raddr = drop_pos;
      S_TK_RF: begin
        rf_we    = (rf_rdata != '0);
        rf_wdata = dec;
      end
      S_DR_RD:  al_raddr = last[IDX_W-1:0];
      S_DR_WR: begin
        rf_we    = 1'b1;
        rf_waddr = drop_e;
        fs_we    = 1'b1;
        al_we    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_idx      <= '0;
      free_depth   <= CNT_W'(POOL_SIZE);
      active_depth <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + CNT_W'(1);
          if (clr_idx == CNT_W'(POOL_SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            life        <= s_tdata[15:0];
            ent         <= s_tdata[16 +: IDX_W];
            res_status  <= ST_OK;
            res_granted <= '0;
            expired     <= '0;
            drop_pos    <= '0;
            walk        <= active_depth;
            case (s_tuser)
              CMD_SPAWN: begin
                if (free_depth == '0) begin
                  res_status <= ST_EXHAUSTED;
                  state      <= S_FIN;
                end else begin
                  state <= S_SP_RD;
                end
              end
              CMD_RELEASE: state <= S_RL_RD;
              CMD_TICK:    state <= S_TK_NEXT;
              default:     state <= S_FIN;
            endcase
          end
        end
        S_SP_RD: state <= S_SP_WR;
        S_SP_WR: begin
          res_granted  <= fs_rdata;
          free_depth   <= free_depth - CNT_W'(1);
          active_depth <= active_depth + CNT_W'(1);
          state        <= S_FIN;
        end
        S_RL_RD: begin
          if (CNT_W'(drop_pos) == active_depth) begin
            res_status <= ST_NOT_ACTIVE;
            state      <= S_FIN;
          end else begin
            state <= S_RL_CMP;
          end
        end
        S_RL_CMP: begin
          if (al_rdata == ent) begin
            drop_e    <= ent;
            drop_tick <= 1'b0;
            state     <= S_DR_RD;
          end else if (drop_pos == IDX_W'(POOL_SIZE - 1)) begin
            res_status <= ST_NOT_ACTIVE;
            state      <= S_FIN;
          end else begin
            drop_pos <= drop_pos + IDX_W'(1);
            state    <= S_RL_RD;
          end
        end
        S_TK_NEXT: begin
          if (walk == '0) begin
            state <= S_FIN;
          end else begin
            walk  <= walk_m1;
            state <= S_TK_RD;
          end
        end
        S_TK_RD: begin
          cur_e <= al_rdata;
          state <= S_TK_RF;
        end
        S_TK_RF: begin
          if (rf_rdata != '0 && dec == '0) begin
            drop_pos  <= walk[IDX_W-1:0];
            drop_e    <= cur_e;
            drop_tick <= 1'b1;
            expired   <= expired + CNT_W'(1);
            state     <= S_DR_RD;
          end else begin
            state <= S_TK_NEXT;
          end
        end
        S_DR_RD: state <= S_DR_WR;
        S_DR_WR: begin
          active_depth <= last;
          free_depth   <= free_depth + CNT_W'(1);
          state        <= drop_tick ? S_TK_NEXT : S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {5'd0, free_depth, active_depth, expired, res_granted};
            state    <= S_IDLE;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

  epl_ram #(.WIDTH(LIFE_W), .DEPTH(POOL_SIZE)) u_frames (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata)
  );

  epl_ram #(.WIDTH(IDX_W), .DEPTH(POOL_SIZE)) u_free (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_raddr), .rdata(fs_rdata)
  );

  epl_ram #(.WIDTH(IDX_W), .DEPTH(POOL_SIZE)) u_active (
    .clk(clk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
    .raddr(al_raddr), .rdata(al_rdata)
  );
endmodule
`default_nettype wire

@@ sv/epl_checker.sv @@
// Port-level assertions for the entry pool, bound to the top level.
`default_nettype none
module epl_checker
  import epl_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [31:0] s_tdata,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic [1:0]  m_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_conserve: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (12'(m_tdata[31:21]) + 12'(m_tdata[42:32])) == 12'(POOL_SIZE))
    else $error("active and free counts do not cover the pool");

  a_exhaust: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_EXHAUSTED |-> m_tdata[42:32] == '0)
    else $error("exhaustion reported with free entries left");

  a_expire: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[20:10] != '0 |-> m_tuser == ST_OK && m_tdata[9:0] == '0)
    else $error("expiry reported on a non-tick result");
endmodule

bind entry_pool_with_lifetime epl_checker u_epl_checker (.*);
`default_nettype wire
